>>> rtl/core/akd_pkg.sv
// shared constants, codes and the ladder window decode for the analog keypad decoder
package akd_pkg;

   localparam int unsigned SampleWidth = 10;
   localparam int unsigned TimeWidth   = 32;
   localparam int unsigned CodeWidth   = 3;
   localparam int unsigned MsWidth     = 16;
   localparam int unsigned CsrAddrWidth = 2;
   localparam int unsigned CsrDataWidth = 16;
   localparam int unsigned ReqDataWidth = 48;
   localparam int unsigned RspDataWidth = 16;

   // button codes
   localparam logic [CodeWidth-1:0] BTN_NONE   = 3'd0;
   localparam logic [CodeWidth-1:0] BTN_RIGHT  = 3'd1;
   localparam logic [CodeWidth-1:0] BTN_UP     = 3'd2;
   localparam logic [CodeWidth-1:0] BTN_DOWN   = 3'd3;
   localparam logic [CodeWidth-1:0] BTN_LEFT   = 3'd4;
   localparam logic [CodeWidth-1:0] BTN_SELECT = 3'd5;

   // register indexes
   localparam logic [CsrAddrWidth-1:0] REG_HOLD_TIME     = 2'd0;
   localparam logic [CsrAddrWidth-1:0] REG_DEBOUNCE      = 2'd1;
   localparam logic [CsrAddrWidth-1:0] REG_CHANGE_DELTA  = 2'd2;
   localparam logic [CsrAddrWidth-1:0] REG_RELEASE_LEVEL = 2'd3;

   // reset values
   localparam logic [MsWidth-1:0]     HOLD_TIME_RESET     = 16'd500;
   localparam logic [MsWidth-1:0]     DEBOUNCE_RESET      = 16'd30;
   localparam logic [SampleWidth-1:0] CHANGE_DELTA_RESET  = 10'd300;
   localparam logic [SampleWidth-1:0] RELEASE_LEVEL_RESET = 10'd1000;
   localparam logic [SampleWidth-1:0] IDLE_SAMPLE         = 10'd1023;

   // ladder windows, lower bound inclusive, upper bound exclusive
   localparam logic [SampleWidth-1:0] RIGHT_HI  = 10'd20;
   localparam logic [SampleWidth-1:0] UP_LO     = 10'd80;
   localparam logic [SampleWidth-1:0] UP_HI     = 10'd120;
   localparam logic [SampleWidth-1:0] DOWN_LO   = 10'd230;
   localparam logic [SampleWidth-1:0] DOWN_HI   = 10'd280;
   localparam logic [SampleWidth-1:0] LEFT_LO   = 10'd380;
   localparam logic [SampleWidth-1:0] LEFT_HI   = 10'd420;
   localparam logic [SampleWidth-1:0] SELECT_LO = 10'd620;
   localparam logic [SampleWidth-1:0] SELECT_HI = 10'd660;

   function automatic logic [CodeWidth-1:0] decode_window(input logic [SampleWidth-1:0] s);
      logic [CodeWidth-1:0] code;
      code = BTN_NONE;
      if (s < RIGHT_HI) begin
         code = BTN_RIGHT;
      end else if (s >= UP_LO && s < UP_HI) begin
         code = BTN_UP;
      end else if (s >= DOWN_LO && s < DOWN_HI) begin
         code = BTN_DOWN;
      end else if (s >= LEFT_LO && s < LEFT_HI) begin
         code = BTN_LEFT;
      end else if (s >= SELECT_LO && s < SELECT_HI) begin
         code = BTN_SELECT;
      end
      return code;
   endfunction

endpackage

>>> rtl/core/analog_keypad_decoder_core.sv
// analog keypad decoder: input register, single-pass decode and state update, result register
// path: an accepted req word is registered in the input register, its rsp word in the
//   result register
// throughput: one word per cycle unless rsp_tready stalls it; the state update is a single
//   pass of compares and a 32-bit subtract between the input register and the result register
// reset: synchronous, active high; clears both valid flags, restores the register defaults
//   and the keypad state (idle sample, no button, no held button, empty latch, time zero)
module analog_keypad_decoder_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // sample[9:0], now_ms[41:10], consume_last[42], zero fill
   input  logic [akd_pkg::ReqDataWidth-1:0]     req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // pressed_button[2:0], held_button[5:3], last_pressed[8:6], zero fill
   output logic [akd_pkg::RspDataWidth-1:0]     rsp_tdata,
   input  logic                                 csr_we,
   input  logic [akd_pkg::CsrAddrWidth-1:0]     csr_addr,
   input  logic [akd_pkg::CsrDataWidth-1:0]     csr_wdata
);

   localparam int unsigned SW = akd_pkg::SampleWidth;
   localparam int unsigned TW = akd_pkg::TimeWidth;
   localparam int unsigned CW = akd_pkg::CodeWidth;
   localparam int unsigned MW = akd_pkg::MsWidth;

   // configuration
   logic [MW-1:0] hold_time_ff;
   logic [MW-1:0] debounce_ff;
   logic [SW-1:0] change_delta_ff;
   logic [SW-1:0] release_level_ff;

   // keypad state; the stored sample doubles as the previous sample, the two never differ
   logic [SW-1:0] sample_ff, sample_in;
   logic [CW-1:0] button_ff, button_in;
   logic [CW-1:0] held_ff, held_in;
   logic [CW-1:0] latched_ff, latched_in;
   logic [TW-1:0] press_time_ff, press_time_in;

   // input register
   logic          in_valid_ff;
   logic [SW-1:0] in_sample_ff;
   logic [TW-1:0] in_now_ff;
   logic          in_consume_ff;

   // result register
   logic          rsp_valid_ff;
   logic [CW-1:0] rsp_pressed_ff, rsp_held_ff, rsp_last_ff;

   logic          rsp_load;
   logic          advance;
   logic [TW-1:0] elapsed;
   logic          hold_hit;
   logic          gated;
   logic [SW-1:0] diff;
   logic          change;
   logic [CW-1:0] decoded;
   logic [CW-1:0] latch_upd;
   logic [CW-1:0] last_in;

   assign rsp_load   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && rsp_load;
   assign req_tready = !in_valid_ff || rsp_load;

   always_comb begin
      elapsed  = in_now_ff - press_time_ff;
      hold_hit = (button_ff != akd_pkg::BTN_NONE) && (elapsed >= {{(TW-MW){1'b0}}, hold_time_ff});
      gated    = (sample_ff < release_level_ff) && (in_sample_ff < release_level_ff);
      diff     = (in_sample_ff >= sample_ff) ? (in_sample_ff - sample_ff)
                                             : (sample_ff - in_sample_ff);
      change   = !gated && (diff >= change_delta_ff)
                 && (elapsed >= {{(TW-MW){1'b0}}, debounce_ff});
      decoded  = akd_pkg::decode_window(in_sample_ff);

      sample_in     = gated ? sample_ff : in_sample_ff;
      button_in     = change ? decoded : button_ff;
      press_time_in = change ? in_now_ff : press_time_ff;
      if (change) begin
         held_in = akd_pkg::BTN_NONE;
      end else if (hold_hit) begin
         held_in = button_ff;
      end else begin
         held_in = held_ff;
      end
      // a press taken in this word is reported at once when consumed
      latch_upd  = change ? decoded : latched_ff;
      last_in    = in_consume_ff ? latch_upd : akd_pkg::BTN_NONE;
      latched_in = in_consume_ff ? akd_pkg::BTN_NONE : latch_upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_time_ff     <= akd_pkg::HOLD_TIME_RESET;
         debounce_ff      <= akd_pkg::DEBOUNCE_RESET;
         change_delta_ff  <= akd_pkg::CHANGE_DELTA_RESET;
         release_level_ff <= akd_pkg::RELEASE_LEVEL_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            akd_pkg::REG_HOLD_TIME:     hold_time_ff     <= csr_wdata;
            akd_pkg::REG_DEBOUNCE:      debounce_ff      <= csr_wdata;
            akd_pkg::REG_CHANGE_DELTA:  change_delta_ff  <= csr_wdata[SW-1:0];
            akd_pkg::REG_RELEASE_LEVEL: release_level_ff <= csr_wdata[SW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff     <= akd_pkg::IDLE_SAMPLE;
         button_ff     <= akd_pkg::BTN_NONE;
         held_ff       <= akd_pkg::BTN_NONE;
         latched_ff    <= akd_pkg::BTN_NONE;
         press_time_ff <= '0;
      end else if (advance) begin
         sample_ff     <= sample_in;
         button_ff     <= button_in;
         held_ff       <= held_in;
         latched_ff    <= latched_in;
         press_time_ff <= press_time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (rsp_load) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_sample_ff  <= req_tdata[SW-1:0];
         in_now_ff     <= req_tdata[SW+TW-1:SW];
         in_consume_ff <= req_tdata[SW+TW];
      end
      if (advance) begin
         rsp_pressed_ff <= button_in;
         rsp_held_ff    <= held_in;
         rsp_last_ff    <= last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(akd_pkg::RspDataWidth-3*CW){1'b0}},
                        rsp_last_ff, rsp_held_ff, rsp_pressed_ff};

   // a held button is always the current button
   a_held_is_current: assert property (@(posedge clock) disable iff (reset)
      held_ff != akd_pkg::BTN_NONE |-> held_ff == button_ff)
      else $error("held button differs from current button");

   // an accepted change restarts the hold and clears held
   a_change_clears_held: assert property (@(posedge clock) disable iff (reset)
      advance && change |=> held_ff == akd_pkg::BTN_NONE && press_time_ff == $past(in_now_ff))
      else $error("accepted change did not restart the hold timer");

   // without consume the latch is never reported
   a_no_consume_no_last: assert property (@(posedge clock) disable iff (reset)
      advance && !in_consume_ff |=> rsp_last_ff == akd_pkg::BTN_NONE)
      else $error("last_pressed reported without consume");

   // button codes stay in range
   a_button_range: assert property (@(posedge clock) disable iff (reset)
      button_ff <= akd_pkg::BTN_SELECT && latched_ff <= akd_pkg::BTN_SELECT)
      else $error("button code out of range");

   // reset empties both stages
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !in_valid_ff && !rsp_valid_ff)
      else $error("pipeline not empty after reset");

endmodule
